// ----- src/rgbconv_pkg.sv -----
`default_nettype none
package rgbconv_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int COEF_FRAC_DEF  = 12;
  localparam int HEIGHT_MAX     = 4096;

  localparam int APB_AW = 6;
  localparam int APB_DW = 64;

  localparam logic [2:0] REG_WIDTH     = 3'd0;
  localparam logic [2:0] REG_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_COEF_LOW  = 3'd2;
  localparam logic [2:0] REG_COEF_MID  = 3'd3;
  localparam logic [2:0] REG_COEF_HIGH = 3'd4;

  typedef struct packed {
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       row_end;
    logic       frame_end;
  } result_t;

  typedef struct packed {
    logic [10:0]      width;
    logic [12:0]      height;
    logic [8:0][15:0] tap;
  } cfg_t;

  typedef struct packed {
    logic [8:0][23:0] win;
    logic             row_end;
    logic             frame_end;
  } win_item_t;

endpackage
`default_nettype wire

// ----- src/rgbconv_ram.sv -----
`default_nettype none
module rgbconv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- src/rgbconv_cfg.sv -----
`default_nettype none
module rgbconv_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [rgbconv_pkg::APB_AW-1:0]      paddr,
  input  wire logic [rgbconv_pkg::APB_DW-1:0]      pwdata,
  output logic      [rgbconv_pkg::APB_DW-1:0]      prdata,
  output logic                                     pready,
  output rgbconv_pkg::cfg_t                        cfg
);

  logic [10:0] img_width;
  logic [12:0] img_height;
  logic [63:0] coef_low;
  logic [63:0] coef_mid;
  logic [15:0] coef_high;
  logic [2:0]  idx;
  logic        wr;

  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= 11'd1024;
      img_height <= 13'd768;
      coef_low   <= 64'd0;
      coef_mid   <= 64'd4096;
      coef_high  <= 16'd0;
    end else if (wr) begin
      unique case (idx)
        rgbconv_pkg::REG_WIDTH:     img_width  <= pwdata[10:0];
        rgbconv_pkg::REG_HEIGHT:    img_height <= pwdata[12:0];
        rgbconv_pkg::REG_COEF_LOW:  coef_low   <= pwdata;
        rgbconv_pkg::REG_COEF_MID:  coef_mid   <= pwdata;
        rgbconv_pkg::REG_COEF_HIGH: coef_high  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rgbconv_pkg::REG_WIDTH:     prdata = 64'(img_width);
      rgbconv_pkg::REG_HEIGHT:    prdata = 64'(img_height);
      rgbconv_pkg::REG_COEF_LOW:  prdata = coef_low;
      rgbconv_pkg::REG_COEF_MID:  prdata = coef_mid;
      rgbconv_pkg::REG_COEF_HIGH: prdata = 64'(coef_high);
      default:                    prdata = '0;
    endcase
  end

  assign cfg.width  = img_width;
  assign cfg.height = img_height;
  assign cfg.tap    = {coef_high, coef_mid, coef_low};

endmodule
`default_nettype wire

// ----- src/rgbconv_line.sv -----
`default_nettype none
module rgbconv_line #(
  parameter int MAX_WIDTH = rgbconv_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  rgbconv_pkg::cfg_t           cfg,
  input  wire logic                   pixel_valid,
  output logic                        pixel_ready,
  input  rgbconv_pkg::pixel_t         pixel,
  output logic                        win_valid,
  input  wire logic                   win_ready,
  output rgbconv_pkg::win_item_t      win_item
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;

  typedef struct packed {
    logic shift;
    logic load;
    logic repl;
    logic top_mid;
    logic bot_mid;
    logic wr;
    logic row_end;
    logic frame_end;
  } s1_flags_t;

  // column / row position and frame state
  logic [CW-1:0] col;
  logic [12:0]   row;
  logic          draining;

  logic [WW-1:0] w_eff;
  logic [12:0]   h_eff;
  logic [31:0]   w_raw;
  logic [13:0]   row_p1;
  logic [13:0]   h_p1;
  logic          c0;
  logic          col_last;
  logic          end_drain;
  logic          take;
  logic          act;
  s1_flags_t     flags;

  // stage 1
  logic          s1_valid;
  s1_flags_t     s1_flags;
  logic [23:0]   s1_pix;
  logic [CW-1:0] s1_addr;
  logic          en2;
  logic          s1_move;

  // line store: {older, newer}
  logic          wr_en;
  logic [47:0]   wr_data;
  logic [47:0]   rd_data;
  logic          fwd_hit;
  logic [47:0]   fwd_data;
  logic [47:0]   eff;
  logic [23:0]   mid;
  logic [23:0]   top;
  logic [23:0]   bot;

  logic [8:0][23:0] win;
  logic [8:0][23:0] res;
  logic [8:0][23:0] win_next;

  always_comb begin
    w_raw = 32'(cfg.width);
    if (w_raw == 32'd0) begin
      w_eff = WW'(1);
    end else if (w_raw > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(w_raw);
    end
    if (cfg.height == 13'd0) begin
      h_eff = 13'd1;
    end else if (cfg.height > 13'(rgbconv_pkg::HEIGHT_MAX)) begin
      h_eff = 13'(rgbconv_pkg::HEIGHT_MAX);
    end else begin
      h_eff = cfg.height;
    end
  end

  assign row_p1    = {1'b0, row} + 14'd1;
  assign h_p1      = {1'b0, h_eff} + 14'd1;
  assign c0        = (col == '0);
  assign col_last  = ({1'b0, col} + WW'(1)) >= w_eff;
  assign end_drain = draining && c0 && ({1'b0, row} >= h_p1);

  assign en2         = !win_valid || win_ready;
  assign s1_move     = s1_valid && en2;
  assign pixel_ready = !s1_valid || en2;
  assign take        = pixel_valid && pixel_ready;
  assign act         = take && (pixel.kind == draining);

  always_comb begin
    flags.shift   = (c0 && row >= 13'd2) || (!c0 && row != 13'd0);
    flags.load    = !c0 && row != 13'd0;
    flags.repl    = c0 && row != 13'd0;
    flags.top_mid = (row == 13'd1);
    flags.bot_mid = draining || (row >= h_eff);
    flags.wr      = !draining;
    flags.row_end = c0 || ({1'b0, col} >= w_eff);
    flags.frame_end = flags.row_end &&
                      (c0 ? ({1'b0, row} >= h_p1) : (row >= h_eff));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      draining <= 1'b0;
    end else if (act) begin
      if (end_drain) begin
        col      <= '0;
        row      <= '0;
        draining <= 1'b0;
      end else if (col_last) begin
        col <= '0;
        if (!draining && row_p1 >= {1'b0, h_eff}) begin
          draining <= 1'b1;
          row      <= h_eff;
        end else begin
          row <= row_p1[12:0];
        end
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_ready) begin
      s1_valid <= act;
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      s1_flags <= flags;
      s1_pix   <= {pixel.red_in, pixel.green_in, pixel.blue_in};
      s1_addr  <= col;
      fwd_hit  <= wr_en && (s1_addr == col);
      fwd_data <= wr_data;
    end
  end

  assign wr_en   = s1_move && s1_flags.wr;
  assign wr_data = {mid, s1_pix};

  rgbconv_ram #(
    .WIDTH (48),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (wr_data),
    .re    (act),
    .raddr (col),
    .rdata (rd_data)
  );

  assign eff = fwd_hit ? fwd_data : rd_data;
  assign mid = eff[23:0];
  assign top = s1_flags.top_mid ? mid : eff[47:24];
  assign bot = s1_flags.bot_mid ? mid : s1_pix;

  always_comb begin
    res = win;
    if (s1_flags.shift) begin
      for (int i = 0; i < 3; i++) begin
        res[3*i]   = win[3*i+1];
        res[3*i+1] = win[3*i+2];
      end
      if (s1_flags.load) begin
        res[2] = top;
        res[5] = mid;
        res[8] = bot;
      end
    end
    win_next = res;
    if (s1_flags.repl) begin
      for (int i = 0; i < 3; i++) begin
        win_next[i]   = top;
        win_next[3+i] = mid;
        win_next[6+i] = bot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win       <= '0;
      win_valid <= 1'b0;
    end else if (en2) begin
      win_valid <= s1_valid && s1_flags.shift;
      if (s1_valid) begin
        win <= win_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      win_item.win       <= res;
      win_item.row_end   <= s1_flags.row_end;
      win_item.frame_end <= s1_flags.frame_end;
    end
  end

  a_act_lands: assert property (@(posedge clk) disable iff (rst)
    act |=> s1_valid)
    else $error("accepted pixel did not reach stage 1");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !en2 |=> s1_valid && $stable(s1_pix) && $stable(s1_addr))
    else $error("stalled stage 1 word lost");

  a_win_stable: assert property (@(posedge clk) disable iff (rst)
    !s1_move |=> $stable(win))
    else $error("window changed without a stage 1 transfer");

endmodule
`default_nettype wire

// ----- src/rgbconv_mac.sv -----
`default_nettype none
module rgbconv_mac #(
  parameter int COEF_FRAC_BITS = rgbconv_pkg::COEF_FRAC_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [8:0][15:0]    tap,
  input  wire logic                win_valid,
  output logic                     win_ready,
  input  rgbconv_pkg::win_item_t   win_item,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output rgbconv_pkg::result_t     result
);

  logic signed [24:0] pfull [3][9];
  logic signed [23:0] prod  [3][9];
  logic               p_valid;
  logic               p_row_end;
  logic               p_frame_end;

  logic signed [25:0] part [3][3];
  logic               s_valid;
  logic               s_row_end;
  logic               s_frame_end;

  logic signed [27:0] tot     [3];
  logic        [27:0] shifted [3];
  logic        [7:0]  chan    [3];

  logic en_p;
  logic en_s;
  logic en_o;

  assign en_o      = !result_valid || result_ready;
  assign en_s      = !s_valid || en_o;
  assign en_p      = !p_valid || en_s;
  assign win_ready = en_p;

  // channel 0 is red, taken from the top byte
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        pfull[ch][k] = 25'($signed({1'b0, win_item.win[k][8*(2-ch) +: 8]})) *
                       25'($signed(tap[k]));
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tot[ch] = 28'(part[ch][0]) + 28'(part[ch][1]) + 28'(part[ch][2]);
      shifted[ch] = tot[ch] >> COEF_FRAC_BITS;
      if (tot[ch] <= 28'sd0) begin
        chan[ch] = 8'd0;
      end else if (shifted[ch] > 28'd255) begin
        chan[ch] = 8'd255;
      end else begin
        chan[ch] = shifted[ch][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      s_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en_p) begin
        p_valid <= win_valid;
      end
      if (en_s) begin
        s_valid <= p_valid;
      end
      if (en_o) begin
        result_valid <= s_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_p && win_valid) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int k = 0; k < 9; k++) begin
          prod[ch][k] <= pfull[ch][k][23:0];
        end
      end
      p_row_end   <= win_item.row_end;
      p_frame_end <= win_item.frame_end;
    end
    if (en_s && p_valid) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int j = 0; j < 3; j++) begin
          part[ch][j] <= 26'(prod[ch][3*j]) + 26'(prod[ch][3*j+1]) +
                         26'(prod[ch][3*j+2]);
        end
      end
      s_row_end   <= p_row_end;
      s_frame_end <= p_frame_end;
    end
    if (en_o && s_valid) begin
      result.red_out   <= chan[0];
      result.green_out <= chan[1];
      result.blue_out  <= chan[2];
      result.row_end   <= s_row_end;
      result.frame_end <= s_frame_end;
    end
  end

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    s_valid && s_frame_end |-> s_row_end)
    else $error("frame end without row end");

  a_p_holds: assert property (@(posedge clk) disable iff (rst)
    p_valid && !en_s |=> p_valid)
    else $error("product stage dropped a word");

  a_s_holds: assert property (@(posedge clk) disable iff (rst)
    s_valid && !en_o |=> s_valid && $stable(s_row_end))
    else $error("sum stage dropped a word");

endmodule
`default_nettype wire

// ----- src/rgb_3x3_convolution.sv -----
`default_nettype none
// Streaming 3x3 RGB convolution with replicated borders. The block takes one
// word per clock while pixel_ready is high, pixels in raster order, and keeps
// the two previous rows in a single 48-bit by MAX_WIDTH line RAM that is read
// and written back once per pixel; that RAM port pair and the 27 unrolled
// multipliers set the rate of one word per cycle. A pixel's result is released
// by the word that arrives image_width+1 words after it and passes through
// stage 1, the window, products, partial sums and output registers to the
// result port, held up by any result_ready stalls.
// After a frame's last pixel send image_width+1 drain words (kind = 1) to
// flush the remaining results. The line RAM needs no clearing after reset.
// Registers may only be written while the block is idle.
module rgb_3x3_convolution #(
  parameter int MAX_WIDTH      = rgbconv_pkg::MAX_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = rgbconv_pkg::COEF_FRAC_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [rgbconv_pkg::APB_AW-1:0]      paddr,
  input  wire logic [rgbconv_pkg::APB_DW-1:0]      pwdata,
  output logic      [rgbconv_pkg::APB_DW-1:0]      prdata,
  output logic                                     pready,
  input  wire logic                                pixel_valid,
  output logic                                     pixel_ready,
  input  rgbconv_pkg::pixel_t                      pixel,
  output logic                                     result_valid,
  input  wire logic                                result_ready,
  output rgbconv_pkg::result_t                     result
);

  rgbconv_pkg::cfg_t      cfg;
  rgbconv_pkg::win_item_t win_item;
  logic                   win_valid;
  logic                   win_ready;

  rgbconv_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rgbconv_line #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .win_valid   (win_valid),
    .win_ready   (win_ready),
    .win_item    (win_item)
  );

  rgbconv_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk          (clk),
    .rst          (rst),
    .tap          (cfg.tap),
    .win_valid    (win_valid),
    .win_ready    (win_ready),
    .win_item     (win_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire
